>>> hdl/glu_pkg.sv
package glu_pkg;

  // Operand and lcm width; fields above it are ignored on input and
  // sign-extended on output.
  parameter int DATA_WIDTH = 64;

  parameter int IN_W    = 64;               // width of each input operand field
  parameter int GCD_W   = 63;               // width of the gcd result field
  parameter int LCM_W   = 64;               // width of the lcm result field
  parameter int SUB_W   = DATA_WIDTH + 2;   // shared subtractor, with borrow bit
  parameter int SHIFT_W = $clog2(DATA_WIDTH);
  parameter int CNT_W   = $clog2(DATA_WIDTH);
  parameter int HALF_W  = (DATA_WIDTH + 1) / 2;
  parameter int PROD_W  = 2 * HALF_W;

  parameter logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_WIDTH - 1);

  typedef struct packed {
    logic signed [IN_W-1:0] operand_a;
    logic signed [IN_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic        [GCD_W-1:0] gcd_value;
    logic signed [LCM_W-1:0] lcm_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS_A,
    ST_ABS_B,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_NEG_Q,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_HOLD,
    DP_LOAD,
    DP_ABS_A,
    DP_ABS_B,
    DP_GCD,
    DP_SCALE,
    DP_DIV,
    DP_NEG_Q,
    DP_MUL
  } dp_op_e;

  // Partial product sequence of the low-half multiply.
  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL,
    MS_ACC
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul_sel;
    logic     in_ready;
    logic     res_load;
  } ctrl_t;

  typedef struct packed {
    logic gcd_done;
  } stat_t;

endpackage

>>> hdl/glu_ctrl.sv
module glu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  input  glu_pkg::stat_t stat_i,
  output glu_pkg::ctrl_t ctrl_o
);

  glu_pkg::state_e             state_q, state_d;
  logic [glu_pkg::CNT_W-1:0]   div_cnt_q, div_cnt_d;
  glu_pkg::mul_sel_e           mul_q, mul_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= glu_pkg::ST_IDLE;
      div_cnt_q <= '0;
      mul_q     <= glu_pkg::MS_LL;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      mul_q     <= mul_d;
    end
  end

  // Next state and step counters
  always_comb begin
    state_d   = state_q;
    div_cnt_d = '0;
    mul_d     = glu_pkg::MS_LL;
    case (state_q)
      glu_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = glu_pkg::ST_ABS_A;
      end
      glu_pkg::ST_ABS_A: state_d = glu_pkg::ST_ABS_B;
      glu_pkg::ST_ABS_B: state_d = glu_pkg::ST_GCD;
      glu_pkg::ST_GCD: begin
        if (stat_i.gcd_done) state_d = glu_pkg::ST_SCALE;
      end
      glu_pkg::ST_SCALE: state_d = glu_pkg::ST_DIV;
      glu_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == glu_pkg::DIV_LAST) state_d = glu_pkg::ST_NEG_Q;
      end
      glu_pkg::ST_NEG_Q: state_d = glu_pkg::ST_MUL;
      glu_pkg::ST_MUL: begin
        mul_d = glu_pkg::mul_sel_e'(mul_q + 1'b1);
        if (mul_q == glu_pkg::MS_ACC) state_d = glu_pkg::ST_DONE;
      end
      glu_pkg::ST_DONE: begin
        if (out_free_i) state_d = glu_pkg::ST_IDLE;
      end
      default: state_d = glu_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.op       = glu_pkg::DP_HOLD;
    ctrl_o.mul_sel  = mul_q;
    case (state_q)
      glu_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) ctrl_o.op = glu_pkg::DP_LOAD;
      end
      glu_pkg::ST_ABS_A: ctrl_o.op = glu_pkg::DP_ABS_A;
      glu_pkg::ST_ABS_B: ctrl_o.op = glu_pkg::DP_ABS_B;
      glu_pkg::ST_GCD:   ctrl_o.op = glu_pkg::DP_GCD;
      glu_pkg::ST_SCALE: ctrl_o.op = glu_pkg::DP_SCALE;
      glu_pkg::ST_DIV:   ctrl_o.op = glu_pkg::DP_DIV;
      glu_pkg::ST_NEG_Q: ctrl_o.op = glu_pkg::DP_NEG_Q;
      glu_pkg::ST_MUL:   ctrl_o.op = glu_pkg::DP_MUL;
      glu_pkg::ST_DONE:  ctrl_o.res_load = out_free_i;
      default:           ctrl_o.op = glu_pkg::DP_HOLD;
    endcase
  end

endmodule

>>> hdl/glu_dpath.sv
module glu_dpath (
  input  logic               clk_i,
  input  glu_pkg::ctrl_t     ctrl_i,
  input  glu_pkg::in_item_t  in_item_i,
  output glu_pkg::stat_t     stat_o,
  output glu_pkg::out_item_t res_o
);

  logic [glu_pkg::DATA_WIDTH-1:0] u_q, u_d, v_q, v_d, ma_q, ma_d, b_q, b_d;
  logic [glu_pkg::DATA_WIDTH-1:0] g_q, g_d, quo_q, quo_d, rem_q, rem_d, acc_q, acc_d;
  logic [glu_pkg::DATA_WIDTH-1:0] g_sat;
  logic [glu_pkg::SHIFT_W-1:0]    k_q, k_d;
  logic                           a_neg_q, a_neg_d;
  logic [glu_pkg::PROD_W-1:0]     prod_q, prod_d, q_ext, b_ext, pp_shift;
  logic [glu_pkg::HALF_W-1:0]     mul_x, mul_y;
  logic [glu_pkg::SUB_W-1:0]      sub_x, sub_y, sub_diff;
  logic                           borrow;

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    v_q     <= v_d;
    ma_q    <= ma_d;
    b_q     <= b_d;
    g_q     <= g_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    a_neg_q <= a_neg_d;
    prod_q  <= prod_d;
  end

  // Shared subtractor: negation, Euclid step compare and divider trial
  always_comb begin
    sub_x = '0;
    sub_y = '0;
    case (ctrl_i.op)
      glu_pkg::DP_ABS_A: sub_y = glu_pkg::SUB_W'(u_q);
      glu_pkg::DP_ABS_B: sub_y = glu_pkg::SUB_W'(v_q);
      glu_pkg::DP_GCD: begin
        sub_x = glu_pkg::SUB_W'(u_q);
        sub_y = glu_pkg::SUB_W'(v_q);
      end
      glu_pkg::DP_DIV: begin
        sub_x = glu_pkg::SUB_W'({rem_q, quo_q[glu_pkg::DATA_WIDTH-1]});
        sub_y = glu_pkg::SUB_W'(g_q);
      end
      glu_pkg::DP_NEG_Q: sub_y = glu_pkg::SUB_W'(quo_q);
      default: begin
        sub_x = '0;
        sub_y = '0;
      end
    endcase
  end

  assign sub_diff = sub_x - sub_y;
  assign borrow   = sub_diff[glu_pkg::SUB_W-1];

  // One 32x32-class partial product per cycle for the low half of q*b
  assign q_ext = glu_pkg::PROD_W'(quo_q);
  assign b_ext = glu_pkg::PROD_W'(b_q);

  always_comb begin
    case (ctrl_i.mul_sel)
      glu_pkg::MS_LL: begin
        mul_x = q_ext[glu_pkg::HALF_W-1:0];
        mul_y = b_ext[glu_pkg::HALF_W-1:0];
      end
      glu_pkg::MS_LH: begin
        mul_x = q_ext[glu_pkg::HALF_W-1:0];
        mul_y = b_ext[glu_pkg::PROD_W-1:glu_pkg::HALF_W];
      end
      glu_pkg::MS_HL: begin
        mul_x = q_ext[glu_pkg::PROD_W-1:glu_pkg::HALF_W];
        mul_y = b_ext[glu_pkg::HALF_W-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // The product held in prod_q came from the previous select
  assign pp_shift = (ctrl_i.mul_sel == glu_pkg::MS_LH) ? prod_q : (prod_q << glu_pkg::HALF_W);

  always_comb begin
    u_d     = u_q;
    v_d     = v_q;
    ma_d    = ma_q;
    b_d     = b_q;
    g_d     = g_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    k_d     = k_q;
    a_neg_d = a_neg_q;
    prod_d  = prod_q;
    case (ctrl_i.op)
      glu_pkg::DP_LOAD: begin
        u_d     = in_item_i.operand_a[glu_pkg::DATA_WIDTH-1:0];
        v_d     = in_item_i.operand_b[glu_pkg::DATA_WIDTH-1:0];
        b_d     = in_item_i.operand_b[glu_pkg::DATA_WIDTH-1:0];
        a_neg_d = in_item_i.operand_a[glu_pkg::DATA_WIDTH-1];
        k_d     = '0;
      end
      glu_pkg::DP_ABS_A: begin
        if (a_neg_q) u_d = sub_diff[glu_pkg::DATA_WIDTH-1:0];
        ma_d = a_neg_q ? sub_diff[glu_pkg::DATA_WIDTH-1:0] : u_q;
      end
      glu_pkg::DP_ABS_B: begin
        if (b_q[glu_pkg::DATA_WIDTH-1]) v_d = sub_diff[glu_pkg::DATA_WIDTH-1:0];
      end
      glu_pkg::DP_GCD: begin
        // Binary Euclid: strip common twos into k, then odd-odd subtract
        if (u_q != '0) begin
          if (v_q == '0) begin
            v_d = u_q;
            u_d = '0;
          end else if (!u_q[0] && !v_q[0]) begin
            u_d = u_q >> 1;
            v_d = v_q >> 1;
            k_d = glu_pkg::SHIFT_W'(k_q + 1'b1);
          end else if (!u_q[0]) begin
            u_d = u_q >> 1;
          end else if (!v_q[0]) begin
            v_d = v_q >> 1;
          end else if (borrow) begin
            u_d = v_q;
            v_d = u_q;
          end else begin
            u_d = sub_diff[glu_pkg::DATA_WIDTH:1];
          end
        end
      end
      glu_pkg::DP_SCALE: begin
        g_d   = v_q << k_q;
        rem_d = '0;
        quo_d = ma_q;
      end
      glu_pkg::DP_DIV: begin
        quo_d = {quo_q[glu_pkg::DATA_WIDTH-2:0], ~borrow};
        rem_d = borrow ? sub_x[glu_pkg::DATA_WIDTH-1:0] : sub_diff[glu_pkg::DATA_WIDTH-1:0];
      end
      glu_pkg::DP_NEG_Q: begin
        if (a_neg_q) quo_d = sub_diff[glu_pkg::DATA_WIDTH-1:0];
        acc_d = '0;
      end
      glu_pkg::DP_MUL: begin
        prod_d = glu_pkg::PROD_W'(mul_x) * glu_pkg::PROD_W'(mul_y);
        if (ctrl_i.mul_sel != glu_pkg::MS_LL) begin
          acc_d = acc_q + pp_shift[glu_pkg::DATA_WIDTH-1:0];
        end
      end
      default: begin
        u_d = u_q;
      end
    endcase
  end

  assign stat_o.gcd_done = (u_q == '0);

  // Saturate a gcd equal to the most negative magnitude
  assign g_sat = g_q[glu_pkg::DATA_WIDTH-1] ? {1'b0, {(glu_pkg::DATA_WIDTH-1){1'b1}}} : g_q;

  assign res_o.gcd_value = glu_pkg::GCD_W'(g_sat);
  assign res_o.lcm_value = glu_pkg::LCM_W'($signed(acc_q));

endmodule

>>> hdl/gcd_lcm_unit.sv
// gcd_lcm_unit: gcd and lcm of two signed operands, one result item per input item.
//
// Input channel (in_valid_i / in_ready_o / in_item_i): operand_a and operand_b, of
// which the low DATA_WIDTH bits are used as signed values. in_ready_o is high only
// while the unit is idle; an item is taken when valid and ready are both high.
// Output channel (out_valid_o / out_ready_i / out_item_o): gcd_value of the
// magnitudes and lcm_value = (a / gcd) * b wrapped to DATA_WIDTH bits.
// Sequence: all work runs on one shared subtractor and one half-width multiplier.
// Per item: a load, the magnitudes of a and then of b, the binary Euclid loop
// (one shift, subtract or swap per cycle, data dependent), a rescale of the gcd,
// restoring division for |a| / gcd, restoring the quotient sign, the partial
// products LL, LH and HL with their accumulation, then the hand-over of the result.
// One item is in work at a time; the next item is taken once the result is
// handed over, while that result may still wait in the output register.
// Stall: if the output register is still full when a result is ready, the
// sequencer holds it until out_ready_i frees the register.
// Reset: rst_ni clears the sequencer and the output valid, so an item in work or
// waiting at the output is dropped; no item is invented across reset.
module gcd_lcm_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  glu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output glu_pkg::out_item_t out_item_o
);

  glu_pkg::ctrl_t     ctrl;
  glu_pkg::stat_t     stat;
  glu_pkg::out_item_t res;
  glu_pkg::out_item_t out_item_q;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  // The output register may be refilled in the cycle its item leaves
  assign out_free = ~out_valid_q | out_ready_i;

  glu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  glu_dpath u_dpath (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .in_item_i (in_item_i),
    .stat_o    (stat),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load only, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl.res_load) out_item_q <= res;
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/glu_checker.sv
module glu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input glu_pkg::out_item_t out_item_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // One item at a time: drop ready right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // A fresh accept never disturbs a waiting result
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || $stable(out_item_o))
    else $error("result changed right after accept");

  // A zero gcd means both operands were zero, so the lcm is zero
  a_zero_lcm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.gcd_value == '0) |-> (out_item_o.lcm_value == '0))
    else $error("nonzero lcm with zero gcd");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (.*);
